### design/lksb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Luma key soft blend package
// Shared constants, select codes and helper functions for the luma keyer.
// ----------------------------------------------------------------------------
package lksb_pkg;

   // Channel positions inside a 32-bit pixel word
   localparam int unsigned RED_SHIFT   = 16;
   localparam int unsigned GREEN_SHIFT = 8;
   localparam int unsigned BLUE_SHIFT  = 0;

   // Luminance weights, sum is 256
   localparam logic [15:0] LUM_R_COEF = 16'd90;
   localparam logic [15:0] LUM_G_COEF = 16'd115;
   localparam logic [15:0] LUM_B_COEF = 16'd51;

   // 255 << 8
   localparam logic [15:0] FULL_SCALE = 16'hFF00;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FUZZINESS = 1'b1;

   // Reset values of the registers and of everything derived from them
   localparam logic [7:0]  THRESHOLD_RST = 8'd128;
   localparam logic [7:0]  FUZZINESS_RST = 8'd8;
   localparam logic [7:0]  WIN_START_RST = 8'd120;
   localparam logic [7:0]  WIN_END_RST   = 8'd136;
   localparam logic [7:0]  WIN_WIDTH_RST = 8'd16;
   localparam logic [7:0]  DIV_QHI_RST   = 8'h0F;   // 0xFF / 16
   localparam logic [7:0]  DIV_REM_RST   = 8'd15;   // 0xFF % 16
   localparam logic [15:0] RAMP_RST      = 16'd4080;

   // Output select code carried down the pipeline
   typedef enum logic [1:0] {
      SEL_B   = 2'd0,
      SEL_A   = 2'd1,
      SEL_MIX = 2'd2
   } sel_type;

   // Pull one 8-bit channel out of a pixel word
   function automatic logic [7:0] chan(input logic [31:0] word, input int unsigned shift);
      logic [31:0] shifted;
      shifted = word >> shift;
      return shifted[7:0];
   endfunction

   // Eight restoring-division steps: returns {quotient bits, remainder}.
   // Remainder in must be below the divisor.
   function automatic logic [15:0] div_step8(input logic [7:0] rem_in,
                                             input logic [7:0] dvd_bits,
                                             input logic [7:0] divisor);
      logic [7:0] rem;
      logic [8:0] trial;
      logic [7:0] quo;
      rem = rem_in;
      quo = 8'd0;
      for (int i = 7; i >= 0; i--) begin
         trial = {rem, dvd_bits[i]};
         if (trial >= {1'b0, divisor}) begin
            trial  = trial - {1'b0, divisor};
            quo[i] = 1'b1;
         end
         rem = trial[7:0];
      end
      return {quo, rem};
   endfunction

endpackage

### design/luma_key_soft_blend.sv
`timescale 1ns / 1ps
// Pipeline: five register stages, s1 to s4 and the output register.
// Throughput: one item per clock; busy stays low, start may be held high every cycle.
// The result receiver cannot stall, so the pipeline never holds and needs no skid stage.
// Reset (synchronous, active high) clears the pipeline valids and loads threshold 128,
// fuzziness 8 and the matching window/ramp values; items may start the cycle after.
// A CSR write passes the window registers before the compare and the divider before the ramp.
// ----------------------------------------------------------------------------
// Luma key soft blend
// Keys foreground pixel A over background pixel B by the luminance of A,
// with a linear soft blend inside a window around the threshold.
// ----------------------------------------------------------------------------
module luma_key_soft_blend (
   input  logic                              clock,
   input  logic                              reset,
   // item request
   input  logic                              start,
   output logic                              busy,
   input  logic [31:0]                       req_pixel_a,
   input  logic [31:0]                       req_pixel_b,
   // item result
   output logic                              rsp_valid,
   output logic [31:0]                       rsp_pixel_out,
   // configuration writes
   input  logic                              csr_we,
   input  logic [lksb_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [7:0]                        csr_wdata
);

   // -------------------------------------------------------------------------
   // Configuration registers
   // -------------------------------------------------------------------------
   logic [7:0] threshold_ff, threshold_in;
   logic [7:0] fuzziness_ff, fuzziness_in;

   always_comb begin
      threshold_in = threshold_ff;
      fuzziness_in = fuzziness_ff;
      if (csr_we) begin
         case (csr_index)
            lksb_pkg::CSR_THRESHOLD: threshold_in = csr_wdata;
            lksb_pkg::CSR_FUZZINESS: fuzziness_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Window derivation, recomputed every cycle from the registers.
   // start = thr - fuz clamped at 0, end = thr + fuz clamped at 255,
   // width = end - start, forced to at least 1 (never above 255 here).
   // -------------------------------------------------------------------------
   logic [8:0] win_diff;
   logic [8:0] win_sum;
   logic [7:0] window_start_ff, window_start_in;
   logic [7:0] window_end_ff,   window_end_in;
   logic [7:0] win_width_ff,    win_width_in;

   always_comb begin
      win_diff        = {1'b0, threshold_ff} - {1'b0, fuzziness_ff};
      win_sum         = {1'b0, threshold_ff} + {1'b0, fuzziness_ff};
      window_start_in = win_diff[8] ? 8'd0   : win_diff[7:0];
      window_end_in   = win_sum[8]  ? 8'hFF  : win_sum[7:0];
      win_width_in    = window_end_in - window_start_in;
      if (win_width_in == 8'd0) begin
         win_width_in = 8'd1;
      end
   end

   // -------------------------------------------------------------------------
   // Ramp multiplier = 0xFF00 / width, a restoring divider split over registers: the upper
   // quotient byte and remainder go into the div registers, then the lower byte into the ramp.
   // -------------------------------------------------------------------------
   logic [15:0] div_hi_res;
   logic [15:0] div_lo_res;
   logic [7:0]  div_qhi_ff,  div_qhi_in;
   logic [7:0]  div_rem_ff,  div_rem_in;
   logic [7:0]  div_dvsr_ff, div_dvsr_in;
   logic [15:0] ramp_multiplier_ff, ramp_multiplier_in;

   always_comb begin
      div_hi_res         = lksb_pkg::div_step8(8'd0, lksb_pkg::FULL_SCALE[15:8], win_width_ff);
      div_qhi_in         = div_hi_res[15:8];
      div_rem_in         = div_hi_res[7:0];
      div_dvsr_in        = win_width_ff;
      div_lo_res         = lksb_pkg::div_step8(div_rem_ff, lksb_pkg::FULL_SCALE[7:0],
                                               div_dvsr_ff);
      ramp_multiplier_in = {div_qhi_ff, div_lo_res[15:8]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff       <= lksb_pkg::THRESHOLD_RST;
         fuzziness_ff       <= lksb_pkg::FUZZINESS_RST;
         window_start_ff    <= lksb_pkg::WIN_START_RST;
         window_end_ff      <= lksb_pkg::WIN_END_RST;
         win_width_ff       <= lksb_pkg::WIN_WIDTH_RST;
         div_qhi_ff         <= lksb_pkg::DIV_QHI_RST;
         div_rem_ff         <= lksb_pkg::DIV_REM_RST;
         div_dvsr_ff        <= lksb_pkg::WIN_WIDTH_RST;
         ramp_multiplier_ff <= lksb_pkg::RAMP_RST;
      end else begin
         threshold_ff       <= threshold_in;
         fuzziness_ff       <= fuzziness_in;
         window_start_ff    <= window_start_in;
         window_end_ff      <= window_end_in;
         win_width_ff       <= win_width_in;
         div_qhi_ff         <= div_qhi_in;
         div_rem_ff         <= div_rem_in;
         div_dvsr_ff        <= div_dvsr_in;
         ramp_multiplier_ff <= ramp_multiplier_in;
      end
   end

   // -------------------------------------------------------------------------
   // Item pipeline
   //   s1: luminance of A
   //   s2: window compare, offset into the window
   //   s3: alpha and its complement
   //   s4: per-channel products
   //   out: channel sums, word assembly, final select
   // -------------------------------------------------------------------------

   // The receiver never stalls, so every item is taken when offered.
   assign busy = 1'b0;

   // ---- stage 1 ----
   logic [15:0] a_red_w, a_grn_w, a_blu_w;
   logic [15:0] lum_sum;
   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_lum_ff,   s1_lum_in;
   logic [31:0] s1_a_ff,     s1_a_in;
   logic [31:0] s1_b_ff,     s1_b_in;

   always_comb begin
      a_red_w     = {8'd0, lksb_pkg::chan(req_pixel_a, lksb_pkg::RED_SHIFT)};
      a_grn_w     = {8'd0, lksb_pkg::chan(req_pixel_a, lksb_pkg::GREEN_SHIFT)};
      a_blu_w     = {8'd0, lksb_pkg::chan(req_pixel_a, lksb_pkg::BLUE_SHIFT)};
      // weights sum to 256, so the total fits 16 bits
      lum_sum     = a_red_w * lksb_pkg::LUM_R_COEF
                  + a_grn_w * lksb_pkg::LUM_G_COEF
                  + a_blu_w * lksb_pkg::LUM_B_COEF;
      s1_valid_in = start && !busy;
      s1_lum_in   = lum_sum[15:8];
      s1_a_in     = req_pixel_a;
      s1_b_in     = req_pixel_b;
   end

   // ---- stage 2 ----
   logic                  s2_valid_ff, s2_valid_in;
   lksb_pkg::sel_type     s2_sel_ff,   s2_sel_in;
   logic [7:0]            s2_offs_ff,  s2_offs_in;
   logic [31:0]           s2_a_ff,     s2_a_in;
   logic [31:0]           s2_b_ff,     s2_b_in;

   always_comb begin
      s2_valid_in = s1_valid_ff;
      // below the window gives B; at or past its end gives A, so an empty window never mixes
      if (s1_lum_ff < window_start_ff) begin
         s2_sel_in = lksb_pkg::SEL_B;
      end else if (s1_lum_ff >= window_end_ff) begin
         s2_sel_in = lksb_pkg::SEL_A;
      end else begin
         s2_sel_in = lksb_pkg::SEL_MIX;
      end
      s2_offs_in = s1_lum_ff - window_start_ff;
      s2_a_in    = s1_a_ff;
      s2_b_in    = s1_b_ff;
   end

   // ---- stage 3 ----
   logic [23:0]           alpha_prod;
   logic                  s3_valid_ff, s3_valid_in;
   lksb_pkg::sel_type     s3_sel_ff,   s3_sel_in;
   logic [15:0]           s3_alpha_ff, s3_alpha_in;
   logic [15:0]           s3_beta_ff,  s3_beta_in;
   logic [31:0]           s3_a_ff,     s3_a_in;
   logic [31:0]           s3_b_ff,     s3_b_in;

   always_comb begin
      s3_valid_in = s2_valid_ff;
      s3_sel_in   = s2_sel_ff;
      // inside the window offs < width, so alpha stays at or below 0xFF00
      alpha_prod  = {16'd0, s2_offs_ff} * {8'd0, ramp_multiplier_ff};
      s3_alpha_in = alpha_prod[15:0];
      s3_beta_in  = lksb_pkg::FULL_SCALE - alpha_prod[15:0];
      s3_a_in     = s2_a_ff;
      s3_b_in     = s2_b_ff;
   end

   // ---- stage 4 ----
   // channel order in the product arrays: 0 red, 1 green, 2 blue
   logic                  s4_valid_ff, s4_valid_in;
   lksb_pkg::sel_type     s4_sel_ff,   s4_sel_in;
   logic [2:0][23:0]      s4_pa_ff,    s4_pa_in;
   logic [2:0][23:0]      s4_pb_ff,    s4_pb_in;
   logic [31:0]           s4_a_ff,     s4_a_in;
   logic [31:0]           s4_b_ff,     s4_b_in;

   always_comb begin
      s4_valid_in = s3_valid_ff;
      s4_sel_in   = s3_sel_ff;
      s4_pa_in[0] = {16'd0, lksb_pkg::chan(s3_a_ff, lksb_pkg::RED_SHIFT)}   * {8'd0, s3_alpha_ff};
      s4_pa_in[1] = {16'd0, lksb_pkg::chan(s3_a_ff, lksb_pkg::GREEN_SHIFT)} * {8'd0, s3_alpha_ff};
      s4_pa_in[2] = {16'd0, lksb_pkg::chan(s3_a_ff, lksb_pkg::BLUE_SHIFT)}  * {8'd0, s3_alpha_ff};
      s4_pb_in[0] = {16'd0, lksb_pkg::chan(s3_b_ff, lksb_pkg::RED_SHIFT)}   * {8'd0, s3_beta_ff};
      s4_pb_in[1] = {16'd0, lksb_pkg::chan(s3_b_ff, lksb_pkg::GREEN_SHIFT)} * {8'd0, s3_beta_ff};
      s4_pb_in[2] = {16'd0, lksb_pkg::chan(s3_b_ff, lksb_pkg::BLUE_SHIFT)}  * {8'd0, s3_beta_ff};
      s4_a_in     = s3_a_ff;
      s4_b_in     = s3_b_ff;
   end

   // ---- output stage ----
   logic [2:0][24:0] mix_sum;
   logic [31:0]      mix_word;
   logic             rsp_valid_ff,     rsp_valid_in;
   logic [31:0]      rsp_pixel_out_ff, rsp_pixel_out_in;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         // sum stays below 2^24 since alpha + beta = 0xFF00
         mix_sum[c] = {1'b0, s4_pa_ff[c]} + {1'b0, s4_pb_ff[c]};
      end
      // blended word keeps only the three channels; overlapping channels OR
      mix_word = ({24'd0, mix_sum[0][23:16]} << lksb_pkg::RED_SHIFT)
               | ({24'd0, mix_sum[1][23:16]} << lksb_pkg::GREEN_SHIFT)
               | ({24'd0, mix_sum[2][23:16]} << lksb_pkg::BLUE_SHIFT);
      rsp_valid_in = s4_valid_ff;
      case (s4_sel_ff)
         lksb_pkg::SEL_B:   rsp_pixel_out_in = s4_b_ff;
         lksb_pkg::SEL_A:   rsp_pixel_out_in = s4_a_ff;
         lksb_pkg::SEL_MIX: rsp_pixel_out_in = mix_word;
         default:           rsp_pixel_out_in = s4_b_ff;
      endcase
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         s4_valid_ff  <= s4_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      s1_lum_ff        <= s1_lum_in;
      s1_a_ff          <= s1_a_in;
      s1_b_ff          <= s1_b_in;
      s2_sel_ff        <= s2_sel_in;
      s2_offs_ff       <= s2_offs_in;
      s2_a_ff          <= s2_a_in;
      s2_b_ff          <= s2_b_in;
      s3_sel_ff        <= s3_sel_in;
      s3_alpha_ff      <= s3_alpha_in;
      s3_beta_ff       <= s3_beta_in;
      s3_a_ff          <= s3_a_in;
      s3_b_ff          <= s3_b_in;
      s4_sel_ff        <= s4_sel_in;
      s4_pa_ff         <= s4_pa_in;
      s4_pb_ff         <= s4_pb_in;
      s4_a_ff          <= s4_a_in;
      s4_b_ff          <= s4_b_in;
      rsp_pixel_out_ff <= rsp_pixel_out_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_out_ff;

endmodule

### design/lksb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Luma key soft blend checker
// Port-level timing checks on item acceptance and result strobes.
// ----------------------------------------------------------------------------
module lksb_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // every taken item gives one result
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_valid)
      else $error("taken item did not produce a result after five cycles");

   // no result without a matching item taken earlier
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 5))
      else $error("result strobe without a matching item");

   // reset empties the pipeline
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   // the keyer never holds off an item
   assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("busy raised");

endmodule

bind luma_key_soft_blend lksb_checker u_lksb_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Luma key soft blend testbench
// Drives pixel pairs and window settings into the keyer and checks every
// keyed pixel against an in-bench luminance key and blend calculation.
// ----------------------------------------------------------------------------
module tb;

   localparam int unsigned CLK_HALF    = 4;
   localparam int unsigned PIPE_DEPTH  = 5;     // register stages from item taken to result
   localparam int unsigned STALL_LIMIT = 2000;  // cycles with no item taken and no result
   localparam int unsigned PHASE_ITEMS = 120;

   // -------------------------------------------------------------------------
   // Scoreboard: keeps its own copy of the window registers, predicts the
   // keyed pixel for every item taken and compares results in order.
   // -------------------------------------------------------------------------
   class luma_key_scoreboard;
      logic [7:0]  threshold;
      logic [7:0]  fuzziness;
      logic [7:0]  win_lo;
      logic [7:0]  win_hi;
      logic [15:0] ramp;
      logic [31:0] expected_pixels[$];
      int unsigned mismatches;

      function new();
         threshold  = lksb_pkg::THRESHOLD_RST;
         fuzziness  = lksb_pkg::FUZZINESS_RST;
         mismatches = 0;
         rederive();
      endfunction

      // Window ends clamp to 0..255, span clamps to 1..255
      function void rederive();
         int lo;
         int hi;
         int span;
         lo = int'(threshold) - int'(fuzziness);
         hi = int'(threshold) + int'(fuzziness);
         if (lo < 0) lo = 0;
         if (lo > 255) lo = 255;
         if (hi < 0) hi = 0;
         if (hi > 255) hi = 255;
         span = hi - lo;
         if (span < 1) span = 1;
         if (span > 255) span = 255;
         win_lo = lo[7:0];
         win_hi = hi[7:0];
         ramp   = 16'(int'(lksb_pkg::FULL_SCALE) / span);
      endfunction

      function void write_register(logic [lksb_pkg::CSR_INDEX_W-1:0] index,
                                   logic [7:0] value);
         if (index == lksb_pkg::CSR_THRESHOLD) begin
            threshold = value;
         end else if (index == lksb_pkg::CSR_FUZZINESS) begin
            fuzziness = value;
         end
         rederive();
      endfunction

      function logic [31:0] keyed_pixel(logic [31:0] fg, logic [31:0] bg);
         int unsigned shifts[3];
         int unsigned luma;
         int unsigned alpha;
         int unsigned inv_alpha;
         int unsigned fa;
         int unsigned ba;
         logic [31:0] mixed;
         shifts = '{lksb_pkg::RED_SHIFT, lksb_pkg::GREEN_SHIFT, lksb_pkg::BLUE_SHIFT};
         luma = ((fg >> lksb_pkg::RED_SHIFT) & 32'hff) * lksb_pkg::LUM_R_COEF
              + ((fg >> lksb_pkg::GREEN_SHIFT) & 32'hff) * lksb_pkg::LUM_G_COEF
              + ((fg >> lksb_pkg::BLUE_SHIFT) & 32'hff) * lksb_pkg::LUM_B_COEF;
         luma = luma >> 8;
         // Empty window falls out of these two compares: nothing lies between
         if (luma < win_lo) return bg;
         if (luma >= win_hi) return fg;
         alpha     = (luma - win_lo) * ramp;
         inv_alpha = int'(lksb_pkg::FULL_SCALE) - alpha;
         mixed     = '0;
         // Blended word carries only the three channels, bits outside are zero
         foreach (shifts[i]) begin
            fa = (fg >> shifts[i]) & 32'hff;
            ba = (bg >> shifts[i]) & 32'hff;
            mixed |= ((fa * alpha + ba * inv_alpha) >> 16) << shifts[i];
         end
         return mixed;
      endfunction

      function void note_item(logic [31:0] fg, logic [31:0] bg);
         expected_pixels.push_back(keyed_pixel(fg, bg));
      endfunction

      function void check_result(logic [31:0] got);
         logic [31:0] want;
         if (expected_pixels.size() == 0) begin
            $error("pixel_out: no item pending, actual %h", got);
            mismatches++;
         end else begin
            want = expected_pixels.pop_front();
            if (got !== want) begin
               $error("pixel_out: expected %h, actual %h", want, got);
               mismatches++;
            end
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT hookup
   // -------------------------------------------------------------------------
   logic                             clock;
   logic                             reset;
   logic                             start;
   logic                             busy;
   logic [31:0]                      req_pixel_a;
   logic [31:0]                      req_pixel_b;
   logic                             rsp_valid;
   logic [31:0]                      rsp_pixel_out;
   logic                             csr_we;
   logic [lksb_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [7:0]                       csr_wdata;

   int unsigned            stall_cycles;
   luma_key_scoreboard     sb;

   luma_key_soft_blend DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_pixel_a   (req_pixel_a),
      .req_pixel_b   (req_pixel_b),
      .rsp_valid     (rsp_valid),
      .rsp_pixel_out (rsp_pixel_out),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_HALF) clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Monitor: everything is sampled on the rising edge, before the DUT's own
   // updates of that edge land. Register writes update the predictor here too.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) sb.write_register(csr_index, csr_wdata);
         if (start && !busy) sb.note_item(req_pixel_a, req_pixel_b);
         if (rsp_valid) sb.check_result(rsp_pixel_out);
         if ((start && !busy) || rsp_valid) begin
            stall_cycles <= 0;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   // Watchdog: a correct run never goes this long without moving an item
   initial begin
      while (stall_cycles < STALL_LIMIT) @(negedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Drivers: all inputs change on the falling edge
   // -------------------------------------------------------------------------
   task automatic send_pair(logic [31:0] fg, logic [31:0] bg);
      @(negedge clock);
      start       <= 1'b1;
      req_pixel_a <= fg;
      req_pixel_b <= bg;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_burst(int unsigned cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // Stop sending and let the pipe empty out completely
   task automatic drain_pipe();
      @(negedge clock);
      start <= 1'b0;
      while (sb.expected_pixels.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 2) @(posedge clock);
   endtask

   // Only called with the pipe empty; waits for the ramp registers to settle
   task automatic set_window(logic [7:0] thr, logic [7:0] fuz);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= lksb_pkg::CSR_THRESHOLD;
      csr_wdata <= thr;
      @(negedge clock);
      csr_index <= lksb_pkg::CSR_FUZZINESS;
      csr_wdata <= fuz;
      @(negedge clock);
      csr_we    <= 1'b0;
      repeat (PIPE_DEPTH) @(posedge clock);
   endtask

   // Gray channels give luminance equal to the channel value
   function automatic logic [31:0] gray_pixel(logic [7:0] top, logic [7:0] level);
      logic [31:0] word;
      word = {top, 24'd0};
      word[lksb_pkg::RED_SHIFT +: 8]   = level;
      word[lksb_pkg::GREEN_SHIFT +: 8] = level;
      word[lksb_pkg::BLUE_SHIFT +: 8]  = level;
      return word;
   endfunction

   // Foreground: mostly near-gray around the current window so the blend
   // ramp gets exercised, the rest fully random
   function automatic logic [31:0] fg_pixel();
      int unsigned shifts[3];
      logic [31:0] word;
      int target;
      int level;
      shifts = '{lksb_pkg::RED_SHIFT, lksb_pkg::GREEN_SHIFT, lksb_pkg::BLUE_SHIFT};
      word   = $urandom;
      if ($urandom_range(0, 3) != 0) begin
         target = int'(sb.win_lo) - 3 + int'($urandom_range(0, sb.win_hi - sb.win_lo + 6));
         foreach (shifts[i]) begin
            level = target + int'($urandom_range(0, 4)) - 2;
            if (level < 0) level = 0;
            if (level > 255) level = 255;
            word[shifts[i] +: 8] = level[7:0];
         end
      end
      return word;
   endfunction

   task automatic run_random(int unsigned count, bit gaps);
      for (int unsigned n = 0; n < count; n++) begin
         send_pair(fg_pixel(), $urandom);
         if (gaps && $urandom_range(0, 5) == 0) idle_burst($urandom_range(1, 12));
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      reset        = 1'b1;
      start        = 1'b0;
      req_pixel_a  = '0;
      req_pixel_b  = '0;
      csr_we       = 1'b0;
      csr_index    = lksb_pkg::CSR_THRESHOLD;
      csr_wdata    = '0;
      stall_cycles = 0;
      sb           = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset window 120..136: both extremes, edges of the window, mid ramp
      send_pair(32'h0000_0000, 32'hFFFF_FFFF);
      send_pair(32'hFFFF_FFFF, 32'h0000_0000);
      send_pair(gray_pixel(8'hA5, 8'd119), 32'h5A12_3456);
      send_pair(gray_pixel(8'hA5, 8'd120), 32'h5A12_3456);
      send_pair(gray_pixel(8'hA5, 8'd121), 32'hC3FE_DCBA);
      send_pair(gray_pixel(8'hFF, 8'd128), 32'hFFFF_FFFF);
      send_pair(gray_pixel(8'hFF, 8'd128), 32'h0000_0000);
      send_pair(gray_pixel(8'h3C, 8'd135), 32'hFF00_FF00);
      send_pair(gray_pixel(8'h3C, 8'd136), 32'h00FF_00FF);
      send_pair(32'h00FF_0000, 32'h1234_5678);   // pure red, dark
      send_pair(32'h00FF_FF00, 32'h1234_5678);   // red plus green, bright
      send_pair(32'h8000_FFFF, 32'h8765_4321);

      // Empty window: fuzziness zero, only below/at-or-above remain
      drain_pipe();
      set_window(8'd100, 8'd0);
      send_pair(gray_pixel(8'h11, 8'd99), 32'hDEAD_BEEF);
      send_pair(gray_pixel(8'h22, 8'd100), 32'hDEAD_BEEF);
      send_pair(gray_pixel(8'h33, 8'd101), 32'hDEAD_BEEF);
      send_pair(gray_pixel(8'h44, 8'd0), 32'hDEAD_BEEF);

      // Full-range window, widest span
      drain_pipe();
      set_window(8'd0, 8'd255);
      send_pair(gray_pixel(8'hEE, 8'd0), 32'hFFFF_FFFF);
      send_pair(gray_pixel(8'hEE, 8'd1), 32'h0000_0000);
      send_pair(gray_pixel(8'hEE, 8'd254), 32'hFFFF_FFFF);
      send_pair(gray_pixel(8'hEE, 8'd255), 32'h0000_0000);

      // Random items across a spread of window settings, reset window and extremes first.
      // One phase pauses halfway until every result is back.
      drain_pipe();
      set_window(8'd128, 8'd8);
      run_random(PHASE_ITEMS / 2, 1'b1);
      drain_pipe();
      run_random(PHASE_ITEMS / 2, 1'b1);

      drain_pipe();
      set_window(8'd0, 8'd0);
      run_random(PHASE_ITEMS, 1'b1);

      drain_pipe();
      set_window(8'd255, 8'd255);
      run_random(PHASE_ITEMS, 1'b1);

      drain_pipe();
      set_window(8'd255, 8'd0);
      run_random(PHASE_ITEMS, 1'b1);

      drain_pipe();
      set_window(8'd255, 8'd1);
      run_random(PHASE_ITEMS, 1'b1);

      drain_pipe();
      set_window(8'd128, 8'd128);
      run_random(PHASE_ITEMS, 1'b1);

      drain_pipe();
      set_window(8'd50, 8'd3);
      run_random(PHASE_ITEMS, 1'b1);

      drain_pipe();
      set_window(8'd200, 8'd40);
      run_random(PHASE_ITEMS, 1'b1);

      repeat (3) begin
         drain_pipe();
         set_window(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         run_random(PHASE_ITEMS, 1'b1);
      end

      // Last stretch back-to-back, no gaps at all
      drain_pipe();
      set_window(8'($urandom_range(0, 255)), 8'($urandom_range(1, 24)));
      run_random(PHASE_ITEMS, 1'b0);

      @(negedge clock);
      start <= 1'b0;
      while (sb.expected_pixels.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 5) @(posedge clock);

      if (sb.mismatches == 0 && sb.expected_pixels.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
